FILE: rtl/core/modbus_tcp_frame_filter_assert.svh
// Assertion macros for the Modbus TCP frame filter
`ifndef MODBUS_TCP_FRAME_FILTER_ASSERT_SVH
`define MODBUS_TCP_FRAME_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
`define MTFF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("mtff assertion failed");
`define MTFF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("mtff assertion failed");
`else
`define MTFF_ASSERT(lbl, clk, rstn, prop)
`define MTFF_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/core/mtff_pkg.sv
// Constants shared by the Modbus TCP frame filter
package mtff_pkg;
  localparam logic [7:0] FcReadCoils     = 8'h01;
  localparam logic [7:0] FcReadDiscrete  = 8'h02;
  localparam logic [7:0] FcReadHolding   = 8'h03;
  localparam logic [7:0] FcReadInput     = 8'h04;
  localparam logic [7:0] FcWriteCoil     = 8'h05;
  localparam logic [7:0] FcWriteReg      = 8'h06;
  localparam logic [7:0] FcReadExcept    = 8'h07;
  localparam logic [7:0] FcDiag          = 8'h08;
  localparam logic [7:0] FcCommCounter   = 8'h0B;
  localparam logic [7:0] FcCommLog       = 8'h0C;
  localparam logic [7:0] FcWriteCoils    = 8'h0F;
  localparam logic [7:0] FcWriteRegs     = 8'h10;
  localparam logic [7:0] FcMaskWrite     = 8'h16;
  localparam logic [7:0] FcReadWriteRegs = 8'h17;
  localparam logic [7:0] FcReadFifo      = 8'h18;
  localparam logic [7:0] FcEncapIface    = 8'h2B;
  localparam logic [7:0] MeiCanOpen      = 8'h0D;
  localparam logic [7:0] MeiDeviceId     = 8'h0E;

  localparam logic [2:0] RsnOk       = 3'd0;
  localparam logic [2:0] RsnShort    = 3'd1;
  localparam logic [2:0] RsnProtocol = 3'd2;
  localparam logic [2:0] RsnRespLen  = 3'd3;
  localparam logic [2:0] RsnFunction = 3'd4;
  localparam logic [2:0] RsnAddress  = 3'd5;
  localparam logic [2:0] RsnValue    = 3'd6;

  localparam logic [3:0] CfgFuncLow    = 4'd0;
  localparam logic [3:0] CfgFuncHigh   = 4'd1;
  localparam logic [3:0] CfgAddrLow    = 4'd2;
  localparam logic [3:0] CfgAddrHigh   = 4'd3;
  localparam logic [3:0] CfgValueLow   = 4'd4;
  localparam logic [3:0] CfgValueHigh  = 4'd5;
  localparam logic [3:0] CfgFuncInvert = 4'd6;
  localparam logic [3:0] CfgValInvert  = 4'd7;
endpackage

FILE: rtl/core/modbus_tcp_frame_filter.sv
// Modbus TCP frame filter: byte-wise header, length, function, address and value checks
//  channel | direction | handshake            | payload
//  in      | input     | in_valid_i/in_stall_o | frame_byte_i, last_byte_i, from_server_i
//  out     | output    | out_valid_o/out_stall_i | frame_ok_o, reject_reason_o
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
// One byte is taken per cycle while the input is not stalled; the frame's verdict
// leaves the result register in the cycle after its last byte is taken, formed from
// the per-byte tracking registers and that byte. Reset clears configuration and frame
// tracking at once. The input stalls only while a verdict is held by a stalled output.
`include "modbus_tcp_frame_filter_assert.svh"
module modbus_tcp_frame_filter import mtff_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  frame_byte_i,
  input  logic        last_byte_i,
  input  logic        from_server_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        frame_ok_o,
  output logic [2:0]  reject_reason_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  logic [7:0]  func_low_q, func_high_q;
  logic [15:0] addr_low_q, addr_high_q, value_low_q, value_high_q;
  logic        func_inv_q, value_inv_q;

  logic [15:0] pos_q;
  logic        dir_q, dir_d, pid_bad_q, pid_bad_d;
  logic [7:0]  fc_q, fc_d, oc_q, oc_d, seen_q, seen_d;
  logic [63:0] field_q, field_d;
  logic [16:0] nos_q, nos_d;

  logic        out_valid_q, ok_q;
  logic [2:0]  reason_q, reason_d;

  logic        in_acc, out_load;
  logic [15:0] p, len, plen;
  logic [7:0]  pb0, pb1, pb2, pb3, pb4, pb5, pb6, pb7;
  logic [15:0] pw0, pw2, pw4, pw6;
  logic        resp_ok, addr_ok, func_match, val_match;

  function automatic logic in_win(input logic [15:0] s, input logic [16:0] e,
                                  input logic [15:0] lo, input logic [15:0] hi);
    in_win = ({1'b0, s} + 17'd1 >= {1'b0, lo}) && (e <= {1'b0, hi});
  endfunction

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_load    = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      func_low_q <= '0; func_high_q <= '0; addr_low_q <= '0; addr_high_q <= '0;
      value_low_q <= '0; value_high_q <= '0; func_inv_q <= 1'b0; value_inv_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgFuncLow:    func_low_q   <= cfg_data_i[7:0];
        CfgFuncHigh:   func_high_q  <= cfg_data_i[7:0];
        CfgAddrLow:    addr_low_q   <= cfg_data_i;
        CfgAddrHigh:   addr_high_q  <= cfg_data_i;
        CfgValueLow:   value_low_q  <= cfg_data_i;
        CfgValueHigh:  value_high_q <= cfg_data_i;
        CfgFuncInvert: func_inv_q   <= cfg_data_i[0];
        CfgValInvert:  value_inv_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    p         = pos_q - 16'd8;
    dir_d     = (pos_q == 16'd0) ? from_server_i : dir_q;
    pid_bad_d = pid_bad_q || ((pos_q == 16'd2 || pos_q == 16'd3) && frame_byte_i != 8'd0);
    fc_d      = (pos_q == 16'd7) ? frame_byte_i : fc_q;
    field_d   = field_q;
    oc_d      = oc_q;
    seen_d    = seen_q;
    nos_d     = nos_q;
    if (pos_q[15:3] == 13'd1) field_d[{pos_q[2:0], 3'b000} +: 8] = frame_byte_i;
    if (pos_q >= 16'd8) begin
      if (p == 16'd5) oc_d = frame_byte_i;
      if ({1'b0, p} == nos_q + 17'd1 && seen_q < oc_d) begin
        nos_d  = nos_q + 17'd2 + {9'd0, frame_byte_i};
        seen_d = seen_q + 8'd1;
      end
    end
  end

  always_comb begin
    len  = (pos_q == 16'hFFFF) ? 16'hFFFF : pos_q + 16'd1;
    plen = len - 16'd8;
    {pb7, pb6, pb5, pb4, pb3, pb2, pb1, pb0} = field_d;
    pw0 = {pb0, pb1};
    pw2 = {pb2, pb3};
    pw4 = {pb4, pb5};
    pw6 = {pb6, pb7};
    case (fc_d)
      FcReadCoils, FcReadDiscrete, FcCommLog, FcReadWriteRegs:
        resp_ok = plen == {8'd0, pb0} + 16'd1;
      FcReadHolding, FcReadInput:
        resp_ok = plen == {7'd0, pb0, 1'b0} + 16'd1;
      FcWriteCoil, FcWriteReg, FcDiag, FcCommCounter, FcWriteCoils, FcWriteRegs:
        resp_ok = plen == 16'd4;
      FcReadExcept: resp_ok = plen == 16'd1;
      FcMaskWrite:  resp_ok = plen == 16'd6;
      FcReadFifo:   resp_ok = {1'b0, plen} == {1'b0, pw0} + 17'd2;
      FcEncapIface:
        resp_ok = (plen >= 16'd6) && ((pb0 == MeiCanOpen) ||
                  ((pb0 == MeiDeviceId) && seen_d == oc_d && nos_d == {1'b0, plen}));
      default: resp_ok = 1'b1;
    endcase
    case (fc_d)
      FcReadCoils, FcReadDiscrete, FcReadHolding, FcReadInput, FcWriteCoils, FcWriteRegs:
        addr_ok = in_win(pw0, {1'b0, pw0} + {1'b0, pw2}, addr_low_q, addr_high_q);
      FcWriteCoil, FcWriteReg, FcMaskWrite:
        addr_ok = in_win(pw0, {1'b0, pw0}, addr_low_q, addr_high_q);
      FcReadWriteRegs:
        addr_ok = in_win(pw0, {1'b0, pw0} + {1'b0, pw2}, addr_low_q, addr_high_q) &&
                  in_win(pw4, {1'b0, pw4} + {1'b0, pw6}, addr_low_q, addr_high_q);
      default: addr_ok = 1'b1;
    endcase
    if (addr_high_q == 16'd0) addr_ok = 1'b1;
    func_match = ((fc_d >= func_low_q) && (fc_d <= func_high_q)) != func_inv_q;
    val_match  = ((pw2 >= value_low_q) && (pw2 <= value_high_q)) != value_inv_q;
    if (pos_q < 16'd7) reason_d = RsnShort;
    else if (pid_bad_d) reason_d = RsnProtocol;
    else if (dir_d) reason_d = resp_ok ? RsnOk : RsnRespLen;
    else if (func_high_q != 8'd0 && !func_match) reason_d = RsnFunction;
    else if (!addr_ok) reason_d = RsnAddress;
    else if (value_high_q != 16'd0 && fc_d == FcWriteReg && !val_match) reason_d = RsnValue;
    else reason_d = RsnOk;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; dir_q <= 1'b0; pid_bad_q <= 1'b0; fc_q <= '0; field_q <= '0;
      oc_q <= '0; seen_q <= '0; nos_q <= 17'd6;
    end else if (in_acc) begin
      if (last_byte_i) begin
        pos_q <= '0; dir_q <= 1'b0; pid_bad_q <= 1'b0; fc_q <= '0; field_q <= '0;
        oc_q <= '0; seen_q <= '0; nos_q <= 17'd6;
      end else begin
        if (pos_q != 16'hFFFF) pos_q <= pos_q + 16'd1;
        dir_q <= dir_d; pid_bad_q <= pid_bad_d; fc_q <= fc_d; field_q <= field_d;
        oc_q <= oc_d; seen_q <= seen_d; nos_q <= nos_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= in_acc && last_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && in_acc && last_byte_i) begin
      reason_q <= reason_d;
      ok_q     <= reason_d == RsnOk;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign frame_ok_o      = ok_q;
  assign reject_reason_o = reason_q;

  `MTFF_ASSERT(a_ok_matches, clk_i, rst_ni, out_valid_o |-> (frame_ok_o == (reject_reason_o == RsnOk)))
  `MTFF_ASSERT(a_reason_range, clk_i, rst_ni, out_valid_o |-> (reject_reason_o <= RsnValue))
  `MTFF_ASSERT_NEXT(a_last_gives_result, clk_i, rst_ni, in_acc && last_byte_i, out_valid_q)
  `MTFF_ASSERT_NEXT(a_last_clears_pos, clk_i, rst_ni, in_acc && last_byte_i, pos_q == 16'd0)
endmodule
